### rtl/core/modular_inverse_euclid_assert.svh
// Assertion macros shared by the modular inverse RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MODULAR_INVERSE_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EUCLID_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MIE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mie_pkg.sv
// Package for the modular inverse block: field widths, reset constant, sequencer codes.
// No dependencies.
`timescale 1ns / 1ps

package mie_pkg;

  localparam int unsigned FIELD_BITS = 32;
  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd1000000007;

  localparam int unsigned ST_BITS = 3;
  typedef logic [ST_BITS-1:0] state_t;

  localparam state_t ST_IDLE   = 3'd0;
  localparam state_t ST_REDUCE = 3'd1;
  localparam state_t ST_CHECK  = 3'd2;
  localparam state_t ST_STEP   = 3'd3;
  localparam state_t ST_FINISH = 3'd4;

endpackage

### rtl/core/mie_divstep.sv
// Shared radix-2 restoring divider for the modular inverse block.
// It forms the remainder and, bit by bit, the product of the quotient and a multiplicand.
// Depends on nothing.
`timescale 1ns / 1ps

module mie_divstep #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  input  logic [W-1:0] mult,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] rem,
  output logic [W-1:0] prod
);

  localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  prod_r, prod_nxt;
  logic [W-1:0]  div_r, div_nxt;
  logic [W-1:0]  mul_r, mul_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fits;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    prod_nxt = prod_r;
    div_nxt  = div_r;
    mul_nxt  = mul_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      prod_nxt = '0;
      div_nxt  = divisor;
      mul_nxt  = mult;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[W-2:0], 1'b0};
      rem_nxt  = fits ? diff[W-1:0] : trial[W-1:0];
      prod_nxt = {prod_r[W-2:0], 1'b0} + (fits ? mul_r : '0);
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    div_r  <= div_nxt;
    mul_r  <= mul_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;
  assign prod = prod_r;

endmodule

### rtl/core/modular_inverse_euclid.sv
// Modular inverse of one operand per transfer by the extended Euclidean algorithm.
// Each operand is first reduced by the modulus, then each Euclid step takes one run of the
// single shared one-bit-per-cycle divider; a 32-bit word takes up to about 46 steps.
// One operand is in work at a time and in_tready is low meanwhile; a finished result
// waits in the output register while the next operand is taken. When the gcd is not 1
// the result is 1 with no_inverse set. Depends on mie_pkg, mie_divstep and
// modular_inverse_euclid_assert.svh.
`timescale 1ns / 1ps

module modular_inverse_euclid #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [mie_pkg::FIELD_BITS-1:0] cfg_wdata,   // modulus
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mie_pkg::FIELD_BITS-1:0] in_tdata,    // operand_value
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mie_pkg::FIELD_BITS-1:0] out_tdata,   // inverse
  output logic                           out_tuser    // no_inverse
);

  import mie_pkg::*;

  localparam int unsigned W = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;

  state_t       state_r, state_nxt;
  logic [W-1:0] mod_r, mod_nxt;
  logic [W-1:0] rprev_r, rprev_nxt;
  logic [W-1:0] rcur_r, rcur_nxt;
  logic [W-1:0] mprev_r, mprev_nxt;
  logic [W-1:0] mcur_r, mcur_nxt;
  logic         nprev_r, nprev_nxt;
  logic         ncur_r, ncur_nxt;
  logic [W-1:0] inv_r, inv_nxt;
  logic         flag_r, flag_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [W-1:0] odata_r, odata_nxt;
  logic         oflag_r, oflag_nxt;

  logic         div_start;
  logic [W-1:0] div_dividend;
  logic [W-1:0] div_divisor;
  logic [W-1:0] div_mult;
  logic         div_busy;
  logic         div_done;
  logic [W-1:0] div_rem;
  logic [W-1:0] div_prod;
  logic [W-1:0] red;
  logic         in_xfer;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign red       = (mprev_r == mod_r) ? '0 : mprev_r;

  mie_divstep #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .mult     (div_mult),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem),
    .prod     (div_prod)
  );

  always_comb begin
    state_nxt    = state_r;
    mod_nxt      = cfg_wen ? cfg_wdata[W-1:0] : mod_r;
    rprev_nxt    = rprev_r;
    rcur_nxt     = rcur_r;
    mprev_nxt    = mprev_r;
    mcur_nxt     = mcur_r;
    nprev_nxt    = nprev_r;
    ncur_nxt     = ncur_r;
    inv_nxt      = inv_r;
    flag_nxt     = flag_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    odata_nxt    = odata_r;
    oflag_nxt    = oflag_r;
    div_start    = 1'b0;
    div_dividend = in_tdata[W-1:0];
    div_divisor  = mod_r;
    div_mult     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mod_r == '0) begin
            inv_nxt   = W'(1);
            flag_nxt  = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (div_done) begin
          rprev_nxt = mod_r;
          rcur_nxt  = div_rem;
          mprev_nxt = '0;
          mcur_nxt  = W'(1);
          nprev_nxt = 1'b0;
          ncur_nxt  = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        div_dividend = rprev_r;
        div_divisor  = rcur_r;
        div_mult     = mcur_r;
        if (rcur_r == '0) begin
          if (rprev_r == W'(1)) begin
            inv_nxt  = (nprev_r && red != '0) ? mod_r - red : red;
            flag_nxt = 1'b0;
          end else begin
            inv_nxt  = W'(1);
            flag_nxt = 1'b1;
          end
          state_nxt = ST_FINISH;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (div_done) begin
          rprev_nxt = rcur_r;
          rcur_nxt  = div_rem;
          mprev_nxt = mcur_r;
          mcur_nxt  = div_prod + mprev_r;
          nprev_nxt = ncur_r;
          ncur_nxt  = !ncur_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = inv_r;
          oflag_nxt  = flag_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mod_r    <= W'(MODULUS_RESET);
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mod_r    <= mod_nxt;
      ovalid_r <= ovalid_nxt;
    end
    rprev_r <= rprev_nxt;
    rcur_r  <= rcur_nxt;
    mprev_r <= mprev_nxt;
    mcur_r  <= mcur_nxt;
    nprev_r <= nprev_nxt;
    ncur_r  <= ncur_nxt;
    inv_r   <= inv_nxt;
    flag_r  <= flag_nxt;
    odata_r <= odata_nxt;
    oflag_r <= oflag_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = FIELD_BITS'(odata_r);
  assign out_tuser  = oflag_r;

`include "modular_inverse_euclid_assert.svh"

  `MIE_ASSERT_SAME(a_ready_div_idle, in_tready, !div_busy, "Divider busy while accepting.")
  `MIE_ASSERT_SAME(a_done_in_div_state, div_done,
    (state_r == ST_REDUCE) || (state_r == ST_STEP), "Divider finished in a wrong state.")
  `MIE_ASSERT_SAME(a_no_inv_is_one, out_tvalid && out_tuser,
    out_tdata == FIELD_BITS'(1), "No-inverse result is not one.")
  `MIE_ASSERT_NEXT(a_start_busy, div_start, div_busy, "Divider did not start.")

endmodule
